// ===== sv/pbaa_pkg.sv =====
package pbaa_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned BASE_W   = 12;
  localparam int unsigned INDEX_W  = 16;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLICE_W  = 26;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned SUM_W    = 17;

  localparam logic [KIND_W-1:0] KIND_RAW_WR  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RAW_RD  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ELEM_WR = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ELEM_RD = 3'd3;
  localparam logic [KIND_W-1:0] KIND_APPEND  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_WIDTH = 2'd2;

  localparam logic [2:0] K_MAX = 3'd5;

  function automatic logic [WORD_W-1:0] elem_mask(input logic [2:0] k);
    logic [WORD_W-1:0] m;
    case (k)
      3'd0: m = 32'h0000_0001;
      3'd1: m = 32'h0000_0003;
      3'd2: m = 32'h0000_000F;
      3'd3: m = 32'h0000_00FF;
      3'd4: m = 32'h0000_FFFF;
      3'd5: m = 32'hFFFF_FFFF;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/pbaa_if.sv =====
interface pbaa_in_if;
  logic                          valid;
  logic                          ready;
  logic [pbaa_pkg::KIND_W-1:0]   kind;
  logic [pbaa_pkg::BASE_W-1:0]   array_base;
  logic [pbaa_pkg::INDEX_W-1:0]  element_index;
  logic [pbaa_pkg::WORD_W-1:0]   data_in;

  modport source (output valid, kind, array_base, element_index, data_in, input ready);
  modport sink (input valid, kind, array_base, element_index, data_in, output ready);
endinterface

interface pbaa_out_if;
  logic                           valid;
  logic                           ready;
  logic [pbaa_pkg::STATUS_W-1:0]  status;
  logic [pbaa_pkg::WORD_W-1:0]    read_value;
  logic [pbaa_pkg::SLICE_W-1:0]   slice_word;
  logic [pbaa_pkg::LEN_W-1:0]     arr_len;

  modport source (output valid, status, read_value, slice_word, arr_len, input ready);
  modport sink (input valid, status, read_value, slice_word, arr_len, output ready);
endinterface

// ===== sv/pbaa_mem.sv =====
module pbaa_mem #(
  parameter int DEPTH = 4096
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic                            we,
  input  logic [$clog2(DEPTH)-1:0]        addr,
  input  logic [pbaa_pkg::WORD_W-1:0]     wdata,
  output logic [pbaa_pkg::WORD_W-1:0]     rdata
);

  logic [pbaa_pkg::WORD_W-1:0] mem [DEPTH];
  logic [pbaa_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/pbaa_wrap.sv =====
module pbaa_wrap #(
  parameter int MEM_DEPTH = 4096
) (
  input  logic                           clk,
  input  logic                           load,
  input  logic [pbaa_pkg::SUM_W-1:0]     x,
  output logic [$clog2(MEM_DEPTH)-1:0]   r
);

  localparam int AW = $clog2(MEM_DEPTH);
  localparam int SH = pbaa_pkg::SUM_W + AW;
  localparam int MW = SH - 5;
  localparam int PW = pbaa_pkg::SUM_W + MW;
  localparam int QW = PW - SH;
  localparam logic [63:0] RECIP = ((64'd1 << SH) / 64'(MEM_DEPTH)) + 64'd1;
  localparam logic [pbaa_pkg::SUM_W-1:0] DEPTH_C = pbaa_pkg::SUM_W'(MEM_DEPTH);

  logic [PW-1:0]               prod;
  logic [pbaa_pkg::SUM_W-1:0]  x_r;
  logic [QW-1:0]               q_r;
  logic [pbaa_pkg::SUM_W-1:0]  rem;

  // The quotient by reciprocal is exact over the whole input range.
  assign prod = PW'(x) * PW'(RECIP[MW-1:0]);

  always_ff @(posedge clk) begin
    if (load) begin
      x_r <= x;
      q_r <= prod[PW-1:SH];
    end
  end

  assign rem = x_r - pbaa_pkg::SUM_W'(pbaa_pkg::SUM_W'(q_r) * DEPTH_C);
  assign r   = rem[AW-1:0];

endmodule

// ===== sv/packed_bit_array_access_unit.sv =====
// Packed bit-field array access over a single-port word memory.
// Input channel in_chan carries one word per item: kind, array_base,
// element_index and data_in. Output channel out_chan returns exactly one
// word per item: status, read_value, slice_word and arr_len.
// An item is taken when valid and ready are both high at a rising clock edge.
// Items are handled one at a time. A raw write or an unused kind passes the base
// and done states; a raw read adds the raw data state, a failed element access
// the header state, and a successful one the header, offset, data address and
// data states. The element path is set by the serial use of the one memory port
// (header read, data read, write back) and by the registered address wrap unit,
// which runs once for the header and once for the data word address. The result
// appears on out_chan in the same cycle in which the block turns ready again.
// A finished result sits in an output register; a stalled receiver holds the
// block only when the next result is done and that register is still full.
// Reset is synchronous and active low; it clears the control state only.
// Memory contents are undefined until written, and there is no clearing pass.
module packed_bit_array_access_unit #(
  parameter int MEM_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  pbaa_in_if.sink     in_chan,
  pbaa_out_if.source  out_chan
);

  localparam int AW = $clog2(MEM_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE, ST_BASE, ST_RAWD, ST_HDR, ST_OFF, ST_DADDR, ST_DATA, ST_DONE
  } state_t;

  state_t                              state_r;
  logic [pbaa_pkg::KIND_W-1:0]         kind_r;
  logic [pbaa_pkg::INDEX_W-1:0]        idx_r;
  logic [pbaa_pkg::WORD_W-1:0]         data_r;
  logic [AW-1:0]                       base_r;
  logic [AW-1:0]                       waddr_r;
  logic [2:0]                          k_r;
  logic [4:0]                          start_r;
  logic [pbaa_pkg::SUM_W-1:0]          x2_r;
  logic [pbaa_pkg::STATUS_W-1:0]       res_status_r;
  logic [pbaa_pkg::WORD_W-1:0]         res_value_r;
  logic [pbaa_pkg::SLICE_W-1:0]        res_slice_r;
  logic [pbaa_pkg::LEN_W-1:0]          res_len_r;
  logic                                out_valid_r;
  logic [pbaa_pkg::STATUS_W-1:0]       out_status_r;
  logic [pbaa_pkg::WORD_W-1:0]         out_value_r;
  logic [pbaa_pkg::SLICE_W-1:0]        out_slice_r;
  logic [pbaa_pkg::LEN_W-1:0]          out_len_r;

  logic                                in_acc;
  logic                                wrap_load;
  logic [pbaa_pkg::SUM_W-1:0]          wrap_x;
  logic [AW-1:0]                       wrap_r;
  logic                                mem_en;
  logic                                mem_we;
  logic [AW-1:0]                       mem_addr;
  logic [pbaa_pkg::WORD_W-1:0]         mem_wdata;
  logic [pbaa_pkg::WORD_W-1:0]         mem_rdata;

  logic [pbaa_pkg::LEN_W-1:0]          hdr_len;
  logic [2:0]                          hdr_k;
  logic [pbaa_pkg::LEN_W-1:0]          new_len;
  logic                                is_app;
  logic [pbaa_pkg::LEN_W-1:0]          eff_len;
  logic [pbaa_pkg::INDEX_W-1:0]        eidx;
  logic [pbaa_pkg::STATUS_W-1:0]       hdr_status;
  logic [pbaa_pkg::INDEX_W-1:0]        woff;
  logic [pbaa_pkg::WORD_W-1:0]         fmask;
  logic [pbaa_pkg::WORD_W-1:0]         smask;
  logic [pbaa_pkg::WORD_W-1:0]         new_word;
  logic [4:0]                          end_bit;

  assign in_acc        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE);

  assign wrap_load = in_acc || (state_r == ST_OFF);
  assign wrap_x    = (state_r == ST_OFF) ? x2_r : pbaa_pkg::SUM_W'(in_chan.array_base);

  pbaa_wrap #(.MEM_DEPTH(MEM_DEPTH)) u_wrap (
    .clk  (clk),
    .load (wrap_load),
    .x    (wrap_x),
    .r    (wrap_r)
  );

  pbaa_mem #(.DEPTH(MEM_DEPTH)) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Header decode. Append raises the length before the checks.
  assign hdr_len = mem_rdata[15:0];
  assign hdr_k   = mem_rdata[18:16];
  assign new_len = hdr_len + 16'd1;
  assign is_app  = (kind_r == pbaa_pkg::KIND_APPEND);
  assign eff_len = is_app ? new_len : hdr_len;
  assign eidx    = is_app ? hdr_len : idx_r;
  assign woff    = eidx >> (pbaa_pkg::K_MAX - hdr_k);

  always_comb begin
    if (eidx >= eff_len) begin
      hdr_status = pbaa_pkg::ST_RANGE;
    end else if (hdr_k > pbaa_pkg::K_MAX) begin
      hdr_status = pbaa_pkg::ST_WIDTH;
    end else begin
      hdr_status = pbaa_pkg::ST_OK;
    end
  end

  assign fmask    = pbaa_pkg::elem_mask(k_r);
  assign smask    = fmask << start_r;
  assign new_word = (mem_rdata & ~smask) | ((data_r << start_r) & smask);
  assign end_bit  = 5'(6'(start_r) + (6'd1 << k_r) - 6'd1);

  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = wrap_r;
    mem_wdata = data_r;
    case (state_r)
      ST_BASE: begin
        mem_en = (kind_r <= pbaa_pkg::KIND_APPEND);
        mem_we = (kind_r == pbaa_pkg::KIND_RAW_WR);
      end
      ST_HDR: begin
        mem_en    = is_app;
        mem_we    = is_app;
        mem_addr  = base_r;
        mem_wdata = {mem_rdata[31:16], new_len};
      end
      ST_DADDR: begin
        mem_en = 1'b1;
      end
      ST_DATA: begin
        mem_en    = (kind_r != pbaa_pkg::KIND_ELEM_RD);
        mem_we    = (kind_r != pbaa_pkg::KIND_ELEM_RD);
        mem_addr  = waddr_r;
        mem_wdata = new_word;
      end
      default: begin
        mem_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            kind_r  <= in_chan.kind;
            idx_r   <= in_chan.element_index;
            data_r  <= in_chan.data_in;
            state_r <= ST_BASE;
          end
        end
        ST_BASE: begin
          base_r       <= wrap_r;
          res_status_r <= pbaa_pkg::ST_OK;
          res_value_r  <= '0;
          res_slice_r  <= '0;
          res_len_r    <= '0;
          case (kind_r)
            pbaa_pkg::KIND_RAW_RD:  state_r <= ST_RAWD;
            pbaa_pkg::KIND_ELEM_WR: state_r <= ST_HDR;
            pbaa_pkg::KIND_ELEM_RD: state_r <= ST_HDR;
            pbaa_pkg::KIND_APPEND:  state_r <= ST_HDR;
            default:                state_r <= ST_DONE;
          endcase
        end
        ST_RAWD: begin
          res_value_r <= mem_rdata;
          state_r     <= ST_DONE;
        end
        ST_HDR: begin
          res_len_r    <= eff_len;
          res_status_r <= hdr_status;
          k_r          <= hdr_k;
          start_r      <= 5'(eidx << hdr_k);
          x2_r         <= pbaa_pkg::SUM_W'(base_r) + pbaa_pkg::SUM_W'(1)
                          + pbaa_pkg::SUM_W'(woff);
          if (hdr_status == pbaa_pkg::ST_OK) begin
            state_r <= ST_OFF;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_OFF: begin
          state_r <= ST_DADDR;
        end
        ST_DADDR: begin
          waddr_r <= wrap_r;
          state_r <= ST_DATA;
        end
        ST_DATA: begin
          if (kind_r == pbaa_pkg::KIND_ELEM_RD) begin
            res_value_r <= (mem_rdata >> start_r) & fmask;
            res_slice_r <= {end_bit, start_r, 16'(waddr_r)};
          end else if (waddr_r == base_r) begin
            // The data word is the header itself, so the length may change.
            res_len_r <= new_word[15:0];
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_value_r  <= res_value_r;
            out_slice_r  <= res_slice_r;
            out_len_r    <= res_len_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.read_value = out_value_r;
  assign out_chan.slice_word = out_slice_r;
  assign out_chan.arr_len    = out_len_r;

endmodule

// ===== sv/pbaa_checker.sv =====
module pbaa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [pbaa_pkg::STATUS_W-1:0]   status,
  input logic [pbaa_pkg::WORD_W-1:0]     read_value,
  input logic [pbaa_pkg::SLICE_W-1:0]    slice_word
);

  // A stalled result word keeps its valid and its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status)
      && $stable(read_value) && $stable(slice_word))
    else $error("output word changed while stalled");

  // Items are handled one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

  // A failed access returns no value and no slice.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != pbaa_pkg::ST_OK) |-> (read_value == '0) && (slice_word == '0))
    else $error("error result carries data");

  // An element never crosses a word boundary, so its end bit is not below its start bit.
  a_slice_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (slice_word != '0) |-> slice_word[25:21] >= slice_word[20:16])
    else $error("slice end bit below start bit");

endmodule

bind packed_bit_array_access_unit pbaa_checker u_pbaa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .status     (out_chan.status),
  .read_value (out_chan.read_value),
  .slice_word (out_chan.slice_word)
);
